### design/pcmb_pkg.sv
// ----------------------------------------------------------------------------
// pcmb_pkg: shared types and constants for the palette color map/blend block
// Field widths, register indexes, mode and kind codes, table builder states.
// ----------------------------------------------------------------------------
package pcmb_pkg;

    localparam int CH_W       = 5;             // one color channel
    localparam int COLOR_W    = 3 * CH_W;      // packed 15-bit color
    localparam int PAL_W      = 5;             // palette number
    localparam int ENTRY_W    = 2 * CH_W;      // {contrast, dark} table word
    localparam int CUR_W      = 16;            // 8.8 fixed-point build accumulator
    localparam int REM_W      = 13;            // span below the top level
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [CUR_W-1:0] CUR_TOP = 16'h1f00;  // build ceiling, 31.0
    localparam int SHADOW_LIMIT = 12;   // values below rise at half rate
    localparam int CH_MAX       = 31;
    localparam int COEFF_MAX    = 16;
    localparam int FOG_RB       = 28;   // fog target, red and blue
    localparam int FOG_G        = 31;   // fog target, green
    localparam int PRE_STEPS    = 3;    // darkening steps before the ramp

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_INDEX   = 3'd0,
        CFG_MODE        = 3'd1,
        CFG_BLEND_COEFF = 3'd2,
        CFG_BLEND_COLOR = 3'd3,
        CFG_MAP_KINDS   = 3'd4,
        CFG_CONTRAST_SP = 3'd5,
        CFG_FOG_MASK    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_MAP   = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_FOG   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_DARK     = 2'd1,
        KIND_CONTRAST = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        B_PRE,      // first darkening steps
        B_DIVD,     // launch ramp divide, dark table
        B_WAITD,
        B_DIVC,     // launch ramp divide, contrast table
        B_WAITC,
        B_POST,     // ramp steps
        B_DONE
    } build_state_t;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] quot;
    } div_rsp_t;

endpackage

### design/palette_color_map_blend.sv
// ----------------------------------------------------------------------------
// palette_color_map_blend: per-palette brightness/contrast map and blend
// Pipeline: table read into stage 1, then blend into the output register.
// Throughput: one beat per cycle while the output is not stalled, set by the registered table read port.
// Reset: synchronous, active low; config registers clear to zero, then the
//   table builder fills both maps with s_tready low; config writes are
//   taken throughout.
// ----------------------------------------------------------------------------
module palette_color_map_blend #(
    parameter int MAP_COUNT = 19
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pcmb_pkg::S_TDATA_W-1:0]     s_tdata,   // [14:0] color_in,
                                                          // [19:15] palette_number
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pcmb_pkg::M_TDATA_W-1:0]     m_tdata,   // [14:0] color_out
    // config write port
    input  logic                               cfg_wr_en,
    input  logic [pcmb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcmb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pcmb_pkg::*;

    localparam int MW    = $clog2(MAP_COUNT);
    localparam int AW    = $clog2(MAP_COUNT * 32);
    localparam int DEPTH = MAP_COUNT * 32;
    localparam logic [CH_W:0] MAP_SAT = (CH_W + 1)'(MAP_COUNT);

    // ---------------- channel arithmetic ----------------
    // c + floor((t - c) * 3 / 4)
    function automatic logic [CH_W-1:0] lighten_ch(input logic [CH_W-1:0] c,
                                                   input logic [CH_W-1:0] t);
        logic signed [CH_W+1:0] diff;
        logic signed [CH_W+3:0] prod;
        logic signed [CH_W+3:0] sum;
        begin
            diff = signed'({2'b0, t}) - signed'({2'b0, c});
            prod = (CH_W + 4)'(diff) * (CH_W + 4)'(4'sd3);
            sum  = signed'({4'b0, c}) + (prod >>> 2);
            lighten_ch = sum[CH_W-1:0];
        end
    endfunction

    // c + floor((t - c) * k / 16)
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] t,
                                                 input logic [CH_W-1:0] k);
        logic signed [CH_W+1:0] diff;
        logic signed [CH_W+7:0] prod;
        logic signed [CH_W+7:0] sum;
        begin
            diff = signed'({2'b0, t}) - signed'({2'b0, c});
            prod = (CH_W + 8)'(diff) * (CH_W + 8)'(signed'({1'b0, k}));
            sum  = signed'({8'b0, c}) + (prod >>> 4);
            blend_ch = sum[CH_W-1:0];
        end
    endfunction

    // ---------------- config registers ----------------
    logic [CH_W-1:0]       map_index_reg;
    logic [1:0]            mode_reg;
    logic [CH_W-1:0]       blend_coeff_reg;
    logic [COLOR_W-1:0]    blend_color_reg;
    logic [CFG_DATA_W-1:0] map_kinds_reg;
    logic [3:0]            contrast_sp_reg;
    logic [15:0]           fog_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_index_reg   <= '0;
            mode_reg        <= '0;
            blend_coeff_reg <= '0;
            blend_color_reg <= '0;
            map_kinds_reg   <= '0;
            contrast_sp_reg <= '0;
            fog_mask_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAP_INDEX:   map_index_reg   <= cfg_wdata[CH_W-1:0];
                CFG_MODE:        mode_reg        <= cfg_wdata[1:0];
                CFG_BLEND_COEFF: blend_coeff_reg <= cfg_wdata[CH_W-1:0];
                CFG_BLEND_COLOR: blend_color_reg <= cfg_wdata[COLOR_W-1:0];
                CFG_MAP_KINDS:   map_kinds_reg   <= cfg_wdata;
                CFG_CONTRAST_SP: contrast_sp_reg <= cfg_wdata[3:0];
                CFG_FOG_MASK:    fog_mask_reg    <= cfg_wdata[15:0];
                default: ;       // unmapped index, dropped
            endcase
        end
    end

    // ---------------- table builder ----------------
    logic               tbl_wr_en;
    logic [AW-1:0]      tbl_wr_addr;
    logic [ENTRY_W-1:0] tbl_wr_data;
    logic               build_done;

    pcmb_build #(.MAP_COUNT(MAP_COUNT)) u_build (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .done        (build_done)
    );

    // ---------------- flow control ----------------
    // Stage 1 holds the beat whose table read is in flight; the output
    // register holds the finished color. Stage 1 keeps filling while the
    // output waits, so one more beat is taken under back-pressure.
    logic v1_reg, vo_reg;
    logic en_out, en1, s_acc;

    assign en_out   = !vo_reg || m_tready;
    assign en1      = !v1_reg || en_out;
    assign s_tready = build_done && en1;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- stage 0: decode and table address ----------------
    logic [PAL_W-1:0]   pal;
    logic [COLOR_W-1:0] color_in;
    logic [1:0]         kind;
    logic               sprite;
    logic [CH_W:0]      k_sat;
    logic [MW-1:0]      map_row;
    logic               mode_fog, mode_blend;
    logic               use_map0, sel_c0, blend0, lighten0;

    assign color_in   = s_tdata[COLOR_W-1:0];
    assign pal        = s_tdata[COLOR_W+PAL_W-1:COLOR_W];
    assign kind       = map_kinds_reg[{pal, 1'b0} +: 2];
    assign sprite     = pal[PAL_W-1];
    assign mode_fog   = (mode_reg == MODE_FOG);
    assign mode_blend = (mode_reg == MODE_BLEND);

    // map index past the last map sticks at the last map
    assign k_sat   = ({1'b0, map_index_reg} > MAP_SAT) ? MAP_SAT : {1'b0, map_index_reg};
    assign map_row = MW'(k_sat - 1'b1);

    // fog mode never maps; index zero or kind none means identity
    assign use_map0 = !mode_fog && (kind != KIND_NONE) && (map_index_reg != '0);
    // blend mode: anything but the darkened kind reads the contrast table;
    // map-only: contrast kind, or the forced sprite palette
    assign sel_c0   = mode_blend ? (kind != KIND_DARK)
                                 : ((kind == KIND_CONTRAST) ||
                                    (sprite && (pal[3:0] == contrast_sp_reg)));
    assign blend0   = mode_fog || mode_blend;
    assign lighten0 = mode_fog && sprite && fog_mask_reg[pal[3:0]];

    // ---------------- stage 1 control ----------------
    logic use_map1_reg, sel_c1_reg, blend1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_acc;
            end
            if (en_out) begin
                vo_reg <= v1_reg;
            end
        end
        if (en1) begin
            use_map1_reg <= use_map0;
            sel_c1_reg   <= sel_c0;
            blend1_reg   <= blend0;
        end
    end

    // blend weight above sixteen sticks at sixteen
    logic [CH_W-1:0] coeff;
    assign coeff = (blend_coeff_reg > CH_W'(COEFF_MAX)) ? CH_W'(COEFF_MAX) : blend_coeff_reg;

    // ---------------- per-channel lanes ----------------
    // Each lane owns a copy of the tables so all three channels read at once.
    logic [COLOR_W-1:0] color_res;
    logic [COLOR_W-1:0] out_reg;

    for (genvar gi = 0; gi < 3; gi++) begin : g_ch
        localparam logic [CH_W-1:0] FOG_T = (gi == 1) ? CH_W'(FOG_G) : CH_W'(FOG_RB);

        logic [CH_W-1:0]    ch_raw, ch_lit, ch1_reg, mapped;
        logic [ENTRY_W-1:0] rd;

        assign ch_raw = color_in[gi*CH_W +: CH_W];
        assign ch_lit = lighten0 ? lighten_ch(ch_raw, FOG_T) : ch_raw;

        pcmb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_tbl (
            .aclk  (aclk),
            .we    (tbl_wr_en),
            .waddr (tbl_wr_addr),
            .wdata (tbl_wr_data),
            .re    (en1),
            .raddr ({map_row, ch_raw}),
            .rdata (rd)
        );

        always_ff @(posedge aclk) begin
            if (en1) begin
                ch1_reg <= ch_lit;
            end
        end

        // word is {contrast, dark}
        assign mapped = use_map1_reg ? (sel_c1_reg ? rd[ENTRY_W-1:CH_W] : rd[CH_W-1:0])
                                     : ch1_reg;
        assign color_res[gi*CH_W +: CH_W] =
            blend1_reg ? blend_ch(mapped, blend_color_reg[gi*CH_W +: CH_W], coeff) : mapped;
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_reg <= color_res;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {{(M_TDATA_W-COLOR_W){1'b0}}, out_reg};

    // ---------------- assertions ----------------
    logic [COLOR_W-1:0] ch1_hold;
    assign ch1_hold = {g_ch[2].ch1_reg, g_ch[1].ch1_reg, g_ch[0].ch1_reg};

    // tables are never rewritten while lookups can be in flight
    a_no_write_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr_en |-> !build_done && !s_tready)
        else $error("table write while lookups enabled");

    // once built, the tables stay built until the next reset
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        build_done |=> build_done)
        else $error("build done dropped");

    // a beat in stage 1 behind a stalled output is neither lost nor moved
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && vo_reg && !m_tready |=> v1_reg && vo_reg && $stable(ch1_hold))
        else $error("stage 1 beat lost under stall");
endmodule

### design/pcmb_ram.sv
// ----------------------------------------------------------------------------
// pcmb_ram: generic simple dual-port RAM
// One write port, one read port with registered data and read enable.
// ----------------------------------------------------------------------------
module pcmb_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 608
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### design/pcmb_div.sv
// ----------------------------------------------------------------------------
// pcmb_div: divide by a fixed divisor through a reciprocal multiply
// Quotient registered; done pulses the cycle after start.
// ----------------------------------------------------------------------------
module pcmb_div #(
    parameter int DIVISOR = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcmb_pkg::div_req_t req,
    output pcmb_pkg::div_rsp_t rsp
);
    import pcmb_pkg::*;

    // x / D == (x * ceil(2^S / D)) >> S for every x below 2^REM_W
    localparam int SHIFT   = REM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = REM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);

    logic              done_reg, done_next;
    logic [REM_W-1:0]  quo_reg,  quo_next;
    logic [PROD_W-1:0] prod;

    always_comb begin
        prod      = PROD_W'(req.dividend) * PROD_W'(RECIP);
        done_next = req.start;
        quo_next  = req.start ? prod[SHIFT +: REM_W] : quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

### design/pcmb_build.sv
// ----------------------------------------------------------------------------
// pcmb_build: post-reset table builder
// Walks every channel value, computes the dark and contrast ramps in 8.8
// fixed point and writes one {contrast, dark} word per map.
// ----------------------------------------------------------------------------
module pcmb_build #(
    parameter int MAP_COUNT = 19
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    output logic                                     tbl_wr_en,
    output logic [$clog2(MAP_COUNT*32)-1:0]          tbl_wr_addr,
    output logic [pcmb_pkg::ENTRY_W-1:0]             tbl_wr_data,
    output logic                                     done
);
    import pcmb_pkg::*;

    localparam int MW = $clog2(MAP_COUNT);

    build_state_t     state_reg, state_next;
    logic [CH_W-1:0]  v_reg,      v_next;
    logic [MW-1:0]    m_reg,      m_next;
    logic [CUR_W-1:0] cur_d_reg,  cur_d_next;
    logic [CUR_W-1:0] cur_c_reg,  cur_c_next;
    logic [CUR_W-1:0] base_d_reg, base_d_next;
    logic [CUR_W-1:0] base_c_reg, base_c_next;
    logic [REM_W-1:0] dlt_d_reg,  dlt_d_next;
    logic [REM_W-1:0] dlt_c_reg,  dlt_c_next;

    logic [CUR_W-1:0] pre_d;
    logic [CUR_W-1:0] post_d, post_c;
    logic             shadow;
    logic             last_m, last_v;
    div_req_t         dreq;
    div_rsp_t         drsp;

    function automatic logic [REM_W-1:0] span(input logic [CUR_W-1:0] c);
        logic [CUR_W-1:0] diff;
        begin
            diff = CUR_TOP - c;
            span = (c <= CUR_TOP) ? diff[REM_W-1:0] : '0;
        end
    endfunction

    // one ramp step, with the half-rate lift for shadow values
    function automatic logic [CUR_W-1:0] ramp(input logic [CUR_W-1:0] c,
                                             input logic [CUR_W-1:0] b,
                                             input logic [REM_W-1:0] dl,
                                             input logic             sh);
        logic [CUR_W-1:0] n;
        logic [CUR_W-1:0] d;
        begin
            n = c + {{(CUR_W-REM_W){1'b0}}, dl};
            d = n - b;
            ramp = (sh && !d[CUR_W-1] && (d != '0)) ? n - (d >> 1) : n;
        end
    endfunction

    function automatic logic [CH_W-1:0] entry(input logic [CUR_W-1:0] c);
        entry = (c[CUR_W-1:8] > 8'(CH_MAX)) ? CH_W'(CH_MAX) : c[CH_W+7:8];
    endfunction

    pcmb_div #(.DIVISOR(MAP_COUNT - PRE_STEPS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign shadow = (v_reg < CH_W'(SHADOW_LIMIT));
    assign pre_d  = cur_d_reg - {{(CUR_W-CH_W-4){1'b0}}, v_reg, 4'b0};
    assign post_d = ramp(cur_d_reg, base_d_reg, dlt_d_reg, shadow);
    assign post_c = ramp(cur_c_reg, base_c_reg, dlt_c_reg, shadow);
    assign last_m = (m_reg == MW'(MAP_COUNT - 1));
    assign last_v = (v_reg == CH_W'(CH_MAX));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_PRE:   if (m_reg == MW'(PRE_STEPS - 1)) state_next = B_DIVD;
            B_DIVD:  state_next = B_WAITD;
            B_WAITD: if (drsp.done) state_next = B_DIVC;
            B_DIVC:  state_next = B_WAITC;
            B_WAITC: if (drsp.done) state_next = B_POST;
            B_POST: begin
                if (last_m) begin
                    state_next = last_v ? B_DONE : B_PRE;
                end
            end
            B_DONE:  state_next = B_DONE;
            default: state_next = B_DONE;
        endcase
    end

    // datapath registers
    always_comb begin
        v_next      = v_reg;
        m_next      = m_reg;
        cur_d_next  = cur_d_reg;
        cur_c_next  = cur_c_reg;
        base_d_next = base_d_reg;
        base_c_next = base_c_reg;
        dlt_d_next  = dlt_d_reg;
        dlt_c_next  = dlt_c_reg;
        case (state_reg)
            B_PRE: begin
                cur_d_next = pre_d;
                m_next     = m_reg + 1'b1;
                if (m_reg == MW'(PRE_STEPS - 1)) begin
                    base_d_next = pre_d;
                    base_c_next = cur_c_reg;
                end
            end
            B_WAITD: if (drsp.done) dlt_d_next = drsp.quot;
            B_WAITC: if (drsp.done) dlt_c_next = drsp.quot;
            B_POST: begin
                cur_d_next = post_d;
                cur_c_next = post_c;
                m_next     = m_reg + 1'b1;
                if (last_m) begin
                    v_next     = v_reg + 1'b1;
                    m_next     = '0;
                    cur_d_next = {{(CUR_W-CH_W-8){1'b0}}, v_next, 8'b0};
                    cur_c_next = {{(CUR_W-CH_W-8){1'b0}}, v_next, 8'b0};
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        tbl_wr_en     = 1'b0;
        tbl_wr_data   = {cur_c_reg[CH_W+7:8], pre_d[CH_W+7:8]};
        dreq.start    = 1'b0;
        dreq.dividend = span(base_d_reg);
        done          = 1'b0;
        case (state_reg)
            B_PRE:  tbl_wr_en = 1'b1;
            B_DIVD: dreq.start = 1'b1;
            B_DIVC: begin
                dreq.start    = 1'b1;
                dreq.dividend = span(base_c_reg);
            end
            B_POST: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_data = {entry(post_c), entry(post_d)};
            end
            B_DONE: done = 1'b1;
            default: ;
        endcase
    end

    assign tbl_wr_addr = {m_reg, v_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_PRE;
            v_reg     <= '0;
            m_reg     <= '0;
            cur_d_reg <= '0;
            cur_c_reg <= '0;
        end else begin
            state_reg <= state_next;
            v_reg     <= v_next;
            m_reg     <= m_next;
            cur_d_reg <= cur_d_next;
            cur_c_reg <= cur_c_next;
        end
        base_d_reg <= base_d_next;
        base_c_reg <= base_c_next;
        dlt_d_reg  <= dlt_d_next;
        dlt_c_reg  <= dlt_c_next;
    end
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: palette_color_map_blend stream check
// Streams palette colors through the block under several register settings,
// predicts every recolored beat in the bench and compares it on arrival.
// ----------------------------------------------------------------------------
module testbench;

    import pcmb_pkg::*;

    localparam int MAP_COUNT = 19;

    // Table slots of the local ramp copy
    localparam int RAMP_CONTRAST = 0;
    localparam int RAMP_DARK     = 1;

    // Mode code 3 has no name in the package; the block treats it as map only
    localparam logic [1:0] MODE_ALIAS_MAP = 2'd3;

    // Palette p gets kind p % 4: none, dark, contrast, three
    localparam logic [CFG_DATA_W-1:0] KINDS_ROTATE = 64'hE4E4_E4E4_E4E4_E4E4;

    localparam int DRAIN_LIMIT = 20000;     // cycles a phase may take to empty
    localparam int FREEZE_CYCLES = 400;     // long receiver hold-off

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [PAL_W-1:0]   pal;
    } px_item_t;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [14:0] color_in, [19:15] palette_number
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [14:0] color_out
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    palette_color_map_blend #(
        .MAP_COUNT (MAP_COUNT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local copy of the block state: ramp tables and register shadows
    // ------------------------------------------------------------------------
    logic [CH_W-1:0]    ramp_tbl [2][MAP_COUNT][32];
    logic [4:0]         map_sel     = '0;
    logic [1:0]         mode_sel    = '0;
    logic [4:0]         blend_k     = '0;
    logic [COLOR_W-1:0] blend_tgt   = '0;
    logic [63:0]        pal_kinds   = '0;
    logic [3:0]         contrast_sp = '0;
    logic [15:0]        fog_mask    = '0;

    // Stream bookkeeping
    px_item_t           pending_px [$];      // beats not yet offered
    logic [COLOR_W-1:0] expected_color [$];  // predictions awaiting output
    px_item_t           cur_px;
    logic [COLOR_W-1:0] want_color;
    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int fail_cnt     = 0;
    int tx_gap       = 0;
    int rx_stall     = 0;
    bit tx_gaps_on   = 1'b0;
    bit rx_gaps_on   = 1'b0;
    logic rx_freeze  = 1'b0;

    // Ramp build: three darkening steps (dark table only), then a rise toward
    // 31.0 in 8.8 fixed point; shadows below the limit climb at half rate.
    function automatic void build_ramps();
        int cur, step, base, span, d, e, top;
        top = CUR_TOP;
        for (int t = 0; t < 2; t++) begin
            for (int v = 0; v < 32; v++) begin
                cur  = v << 8;
                step = (t == RAMP_DARK) ? (v << 8) / 16 : 0;
                for (int m = 0; m < PRE_STEPS; m++) begin
                    cur = (cur - step) & 65535;
                    ramp_tbl[t][m][v] = CH_W'(cur >> 8);
                end
                base = cur;
                span = (cur <= top) ? top - cur : 0;
                step = (span / (MAP_COUNT - PRE_STEPS)) & 65535;
                for (int m = PRE_STEPS; m < MAP_COUNT; m++) begin
                    cur = (cur + step) & 65535;
                    if (v < SHADOW_LIMIT) begin
                        d = (cur - base) & 65535;
                        if (d >= 32768)
                            d = d - 65536;
                        if (d > 0)
                            cur = (cur - d / 2) & 65535;
                    end
                    e = cur >> 8;
                    ramp_tbl[t][m][v] = CH_W'((e > CH_MAX) ? CH_MAX : e);
                end
            end
        end
    endfunction

    // c + floor((t - c) * num / 2^sh), wrapped to a channel
    function automatic logic [CH_W-1:0] pull_toward(int c, int t, int num, int sh);
        int d;
        d = (t - c) * num;
        return CH_W'((c + (d >>> sh)) & CH_MAX);
    endfunction

    function automatic logic [COLOR_W-1:0] recolor_px(logic [COLOR_W-1:0] color,
                                                       logic [PAL_W-1:0] pal);
        logic [CH_W-1:0] ch  [3];
        logic [CH_W-1:0] tgt [3];
        logic [1:0]      kind;
        logic            sprite;
        int              sel, coeff, tbl;
        kind   = pal_kinds[2*pal +: 2];
        sprite = pal[PAL_W-1];
        sel    = (map_sel > MAP_COUNT) ? MAP_COUNT : map_sel;
        coeff  = (blend_k > COEFF_MAX) ? COEFF_MAX : blend_k;
        for (int i = 0; i < 3; i++) begin
            ch[i]  = color[CH_W*i +: CH_W];
            tgt[i] = blend_tgt[CH_W*i +: CH_W];
        end
        if (mode_sel == MODE_FOG) begin
            // fog: no map; listed sprite palettes lighten 3/4 first
            if (sprite && fog_mask[pal[3:0]]) begin
                ch[0] = pull_toward(ch[0], FOG_RB, 3, 2);
                ch[1] = pull_toward(ch[1], FOG_G,  3, 2);
                ch[2] = pull_toward(ch[2], FOG_RB, 3, 2);
            end
            for (int i = 0; i < 3; i++)
                ch[i] = pull_toward(ch[i], tgt[i], coeff, 4);
        end else if (mode_sel == MODE_BLEND) begin
            // kind three falls to the contrast table here
            if (kind != KIND_NONE && sel != 0) begin
                tbl = (kind == KIND_DARK) ? RAMP_DARK : RAMP_CONTRAST;
                for (int i = 0; i < 3; i++)
                    ch[i] = ramp_tbl[tbl][sel-1][ch[i]];
            end
            for (int i = 0; i < 3; i++)
                ch[i] = pull_toward(ch[i], tgt[i], coeff, 4);
        end else begin
            // map only (also code 3); kind three uses dark unless forced sprite
            if (kind != KIND_NONE && sel != 0) begin
                tbl = (kind == KIND_CONTRAST || (sprite && pal[3:0] == contrast_sp)) ?
                      RAMP_CONTRAST : RAMP_DARK;
                for (int i = 0; i < 3; i++)
                    ch[i] = ramp_tbl[tbl][sel-1][ch[i]];
            end
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued beats with a random gap drawn per beat; the
    // prediction is taken at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_color.push_back(recolor_px(cur_px.color, cur_px.pal));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_px.size() > 0) begin
                    cur_px = pending_px.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-COLOR_W-PAL_W){1'b0}}, cur_px.pal, cur_px.color};
                    tx_gap = tx_gaps_on ? $urandom_range(0, 13) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each output beat against the oldest prediction, then
    // draws a stall before the next one. rx_freeze overrides everything.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_color.size() == 0) begin
                    $error("color_out: beat with nothing expected, actual %h",
                           m_tdata[COLOR_W-1:0]);
                    fail_cnt++;
                end else begin
                    want_color = expected_color.pop_front();
                    if (m_tdata[COLOR_W-1:0] !== want_color) begin
                        $error("color_out: expected %h, actual %h",
                               want_color, m_tdata[COLOR_W-1:0]);
                        fail_cnt++;
                    end
                end
                rx_stall = rx_gaps_on ? $urandom_range(0, 13) : 0;
            end
            if (rx_freeze) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MAP_INDEX:   map_sel     = val[4:0];
            CFG_MODE:        mode_sel    = val[1:0];
            CFG_BLEND_COEFF: blend_k     = val[4:0];
            CFG_BLEND_COLOR: blend_tgt   = val[COLOR_W-1:0];
            CFG_MAP_KINDS:   pal_kinds   = val;
            CFG_CONTRAST_SP: contrast_sp = val[3:0];
            CFG_FOG_MASK:    fog_mask    = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_px(input logic [COLOR_W-1:0] color, input logic [PAL_W-1:0] pal);
        px_item_t it;
        it.color = color;
        it.pal   = pal;
        pending_px.push_back(it);
        issued_cnt++;
    endtask

    // Wait until every queued beat went in and every prediction came back
    task automatic drain_results();
        int waited;
        waited = 0;
        while ((accepted_cnt != issued_cnt || expected_color.size() != 0) &&
               waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (accepted_cnt != issued_cnt || expected_color.size() != 0) begin
            $error("color_out: %0d beats still expected after drain",
                   expected_color.size() + issued_cnt - accepted_cnt);
            fail_cnt++;
        end
    endtask

    // One random phase: fresh settings with a bias to the extremes, then
    // random colors over all 32 palettes.
    task automatic random_phase(input int n_items, input bit tx_on, input bit rx_on);
        logic [4:0]  map_v, coeff_v;
        logic [14:0] bc_v;
        tx_gaps_on <= tx_on;
        rx_gaps_on <= rx_on;
        case ($urandom_range(0, 4))
            0:       map_v = 5'd0;
            1:       map_v = 5'(MAP_COUNT);
            2:       map_v = 5'd31;
            default: map_v = 5'($urandom_range(1, 31));
        endcase
        case ($urandom_range(0, 4))
            0:       coeff_v = 5'd0;
            1:       coeff_v = 5'(COEFF_MAX);
            2:       coeff_v = 5'd31;
            default: coeff_v = 5'($urandom_range(0, 31));
        endcase
        case ($urandom_range(0, 5))
            0:       bc_v = 15'h0000;
            1:       bc_v = 15'h7FFF;
            default: bc_v = 15'($urandom_range(0, 32767));
        endcase
        write_reg(CFG_MAP_INDEX,   map_v);
        write_reg(CFG_MODE,        $urandom_range(0, 3));
        write_reg(CFG_BLEND_COEFF, coeff_v);
        write_reg(CFG_BLEND_COLOR, bc_v);
        write_reg(CFG_MAP_KINDS,   {$urandom, $urandom});
        write_reg(CFG_CONTRAST_SP, $urandom_range(0, 15));
        write_reg(CFG_FOG_MASK,    $urandom_range(0, 65535));
        for (int i = 0; i < n_items; i++)
            queue_px(COLOR_W'($urandom_range(0, 32767)), PAL_W'($urandom_range(0, 31)));
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        build_ramps();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Map only, deepest map; kinds rotate per palette, sprite 7 forced
        // to contrast. Writes land while the tables are still being built.
        write_reg(CFG_MAP_INDEX,   MAP_COUNT);
        write_reg(CFG_MODE,        MODE_MAP);
        write_reg(CFG_BLEND_COEFF, 0);
        write_reg(CFG_BLEND_COLOR, 0);
        write_reg(CFG_MAP_KINDS,   KINDS_ROTATE);
        write_reg(CFG_CONTRAST_SP, 7);
        write_reg(CFG_FOG_MASK,    16'hFFFF);
        queue_px(15'h7FFF, 0);      // kind none: passes unchanged
        queue_px(15'h7FFF, 1);      // dark
        queue_px(15'h7FFF, 2);      // contrast
        queue_px(15'h0000, 3);      // kind three, background: dark
        queue_px(15'h00AB, 1);      // shadow channels 11, 5, 0
        queue_px(15'h00AB, 2);
        queue_px(15'h2D6B, 19);     // kind three sprite, not forced
        queue_px(15'h2D6B, 23);     // kind three sprite, forced contrast
        queue_px(15'h2D6B, 21);     // dark sprite
        drain_results();

        // Blend after map, map index past the table count saturates
        write_reg(CFG_MAP_INDEX,   25);
        write_reg(CFG_MODE,        MODE_BLEND);
        write_reg(CFG_BLEND_COEFF, 8);
        write_reg(CFG_BLEND_COLOR, 15'h7C1F);
        queue_px(15'h03E0, 1);
        queue_px(15'h03E0, 2);
        queue_px(15'h03E0, 3);      // kind three in blend: contrast
        queue_px(15'h03E0, 0);      // unmapped, still blended
        drain_results();

        // Fog: sprites 0 and 15 lighten, background mask bits ignored
        write_reg(CFG_MODE,        MODE_FOG);
        write_reg(CFG_BLEND_COEFF, 5);
        write_reg(CFG_BLEND_COLOR, 0);
        write_reg(CFG_FOG_MASK,    16'h8001);
        queue_px(15'h0000, 16);
        queue_px(15'h7FFF, 31);
        queue_px(15'h0000, 17);
        queue_px(15'h0000, 0);
        drain_results();

        // Identity map in blend mode, coefficient past sixteen saturates
        write_reg(CFG_MAP_INDEX,   0);
        write_reg(CFG_MODE,        MODE_BLEND);
        write_reg(CFG_BLEND_COEFF, 31);
        write_reg(CFG_BLEND_COLOR, 15'h4210);
        queue_px(15'h7FFF, 2);
        queue_px(15'h0000, 5);
        drain_results();

        // Mode code 3 acts as map only
        write_reg(CFG_MAP_INDEX,   1);
        write_reg(CFG_MODE,        MODE_ALIAS_MAP);
        queue_px(15'h7FFF, 2);
        queue_px(15'h7FFF, 1);
        drain_results();

        // Back-pressure: receiver frozen while the sender streams at full
        // rate, so the pipeline fills and s_tready drops.
        fork
            begin
                @(posedge aclk);
                rx_freeze <= 1'b1;
                repeat (FREEZE_CYCLES) @(posedge aclk);
                rx_freeze <= 1'b0;
            end
        join_none
        random_phase(200, 1'b0, 1'b0);

        // Random phases cycle through idle patterns: none, both, tx, rx
        for (int p = 0; p < 12; p++)
            random_phase(140, (p % 4 == 1) || (p % 4 == 2), (p % 4 == 1) || (p % 4 == 3));

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
